/* sv/mlfs_pkg.sv */
// ----------------------------------------------------------------------------
// mlfs_pkg
// Shared types and constants for the multilevel feedback scheduler.
// ----------------------------------------------------------------------------
package mlfs_pkg;

  localparam int LEVELS_DEF      = 3;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int PID_BITS_DEF    = 16;
  localparam int TIME_BITS_DEF   = 16;

  // event codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_ARRIV = 2'd1;
  localparam logic [1:0] OP_IO    = 2'd2;
  localparam logic [1:0] OP_TERM  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NO_RUN = 2'd2;

  localparam logic [7:0] IO_WAIT_RESET = 8'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic latch;      // capture event word and snapshot previous run state
    logic tick;       // advance time
    logic io_read;    // fetch io head entry (registered read)
    logic io_pop;     // release io head to ready
    logic quantum;    // tick quantum handling
    logic arrive;     // push arrival
    logic io_req;     // move running to io queue
    logic term;       // drop running
    logic dispatch;   // pick lowest-numbered (highest-priority) nonempty level
    logic rd_front;   // read front of current level
    logic finish;     // load output register
    logic no_run;     // mark no-running status
  } mlfs_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       running;
    logic       io_left;  // entries of this drain still to check
    logic       io_due;   // fetched head entry is due
    logic       q_done;   // quantum has run out
  } mlfs_stat_t;

endpackage

/* sv/mlfs_dpath.sv */
// ----------------------------------------------------------------------------
// mlfs_dpath
// Queues, timers and result register of the scheduler.
// ----------------------------------------------------------------------------
module mlfs_dpath import mlfs_pkg::*; #(
  parameter int LEVELS      = LEVELS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int PID_BITS    = PID_BITS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic [1:0]          ev_op,
  input  logic [PID_BITS-1:0] ev_pid,
  input  mlfs_cmd_t           cmd,
  output mlfs_stat_t          stat,
  output logic                res_run_valid,
  output logic [PID_BITS-1:0] res_run_pid,
  output logic [1:0]          res_run_level,
  output logic                res_switched,
  output logic                res_all_idle,
  output logic [1:0]          res_status
);

  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(LEVELS * QUEUE_DEPTH);
  localparam int QTW = LEVELS;  // quantum up to 2^(LEVELS-1)
  localparam int IOW = PID_BITS + LW + TIME_BITS;

  logic [7:0] wait_r;
  logic [1:0] op_r;
  logic [PID_BITS-1:0] pid_r;
  logic [QW-1:0] rhead_r [LEVELS];
  logic [QW-1:0] rtail_r [LEVELS];
  logic [CW-1:0] rcnt_r  [LEVELS];
  logic [QW-1:0] iohead_r, iotail_r;
  logic [CW-1:0] iocnt_r, drain_r;
  logic [TIME_BITS-1:0] now_r;
  logic [LW-1:0] cur_r;
  logic running_r;
  logic [QTW-1:0] qleft_r;
  logic [1:0] status_r;
  logic prev_valid_r;
  logic [PID_BITS-1:0] prev_pid_r, front_r;
  logic [LW-1:0] prev_lvl_r;

  // memories
  logic [PID_BITS-1:0] rmem [LEVELS*QUEUE_DEPTH];
  logic [IOW-1:0] iomem [QUEUE_DEPTH];
  logic [IOW-1:0] iord_r;

  function automatic logic [AW-1:0] addr(input logic [LW-1:0] lv, input logic [QW-1:0] sl);
    addr = AW'(lv) * AW'(QUEUE_DEPTH) + AW'(sl);
  endfunction

  function automatic logic [QW-1:0] nxt(input logic [QW-1:0] i);
    nxt = (32'(i) + 1 >= QUEUE_DEPTH) ? '0 : QW'(32'(i) + 1);
  endfunction

  // io head decode
  logic [PID_BITS-1:0] io_pid;
  logic [LW-1:0] io_lvl, io_up;
  logic [TIME_BITS-1:0] io_start, age;
  assign {io_pid, io_lvl, io_start} = iord_r;
  assign age = now_r - io_start;
  assign io_up = (io_lvl != '0) ? io_lvl - LW'(1) : '0;

  // dispatch search over levels
  logic any_rdy;
  logic [LW-1:0] pick;
  always_comb begin
    any_rdy = 1'b0;
    pick = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (rcnt_r[i] != '0) begin
        any_rdy = 1'b1;
        pick = LW'(i);
      end
    end
  end

  logic io_idle;
  always_comb begin
    io_idle = (iocnt_r == '0);
    for (int i = 0; i < LEVELS; i++)
      if (rcnt_r[i] != '0) io_idle = 1'b0;
  end

  logic [LW-1:0] dem;
  assign dem = (32'(cur_r) + 1 < LEVELS) ? cur_r + LW'(1) : cur_r;

  assign stat.op = op_r;
  assign stat.running = running_r;
  assign stat.io_left = (drain_r != '0);
  assign stat.io_due = ({{(32-TIME_BITS){1'b0}}, age} >= 32'(wait_r));
  assign stat.q_done = (qleft_r == '0);

  // memory write/read
  logic rwe;
  logic [AW-1:0] rwa;
  logic [PID_BITS-1:0] rwd;
  always_comb begin
    rwe = 1'b0;
    rwa = addr(cur_r, rtail_r[cur_r]);
    rwd = pid_r;
    if (cmd.arrive && rcnt_r[0] != CW'(QUEUE_DEPTH)) begin
      rwe = 1'b1;
      rwa = addr('0, rtail_r[0]);
    end else if (cmd.io_pop && rcnt_r[io_up] != CW'(QUEUE_DEPTH)) begin
      rwe = 1'b1;
      rwa = addr(io_up, rtail_r[io_up]);
      rwd = io_pid;
    end else if (cmd.quantum && qleft_r <= QTW'(1) && rcnt_r[dem] != CW'(QUEUE_DEPTH)) begin
      rwe = 1'b1;
      rwa = addr(dem, rtail_r[dem]);
      rwd = front_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rwe) rmem[rwa] <= rwd;
    if (cmd.rd_front) front_r <= rmem[addr(cur_r, rhead_r[cur_r])];
    if (cmd.io_req && iocnt_r != CW'(QUEUE_DEPTH))
      iomem[iotail_r] <= {front_r, cur_r, now_r};
    if (cmd.io_read) iord_r <= iomem[iohead_r];
    if (cmd.latch) begin
      op_r <= ev_op;
      pid_r <= ev_pid;
      prev_valid_r <= running_r;
      prev_pid_r <= running_r ? front_r : '0;
      prev_lvl_r <= running_r ? cur_r : '0;
    end
  end

  // control state of the queues
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r <= IO_WAIT_RESET;
      for (int i = 0; i < LEVELS; i++) begin
        rhead_r[i] <= '0;
        rtail_r[i] <= '0;
        rcnt_r[i] <= '0;
      end
      iohead_r <= '0;
      iotail_r <= '0;
      iocnt_r <= '0;
      drain_r <= '0;
      now_r <= '0;
      cur_r <= '0;
      running_r <= 1'b0;
      qleft_r <= '0;
      status_r <= ST_OK;
      res_run_valid <= 1'b0;
      res_run_pid <= '0;
      res_run_level <= '0;
      res_switched <= 1'b0;
      res_all_idle <= 1'b1;
      res_status <= ST_OK;
    end else begin
      if (cfg_we) wait_r <= cfg_wdata;
      if (cmd.latch) status_r <= ST_OK;
      if (cmd.tick) begin
        now_r <= now_r + TIME_BITS'(1);
        drain_r <= iocnt_r;
      end
      if (cmd.io_pop) begin
        iohead_r <= nxt(iohead_r);
        iocnt_r <= iocnt_r - CW'(1);
        drain_r <= drain_r - CW'(1);
        if (rcnt_r[io_up] != CW'(QUEUE_DEPTH)) begin
          rtail_r[io_up] <= nxt(rtail_r[io_up]);
          rcnt_r[io_up] <= rcnt_r[io_up] + CW'(1);
        end else status_r <= ST_FULL;
      end
      if (cmd.arrive) begin
        if (rcnt_r[0] != CW'(QUEUE_DEPTH)) begin
          rtail_r[0] <= nxt(rtail_r[0]);
          rcnt_r[0] <= rcnt_r[0] + CW'(1);
        end else status_r <= ST_FULL;
      end
      if (cmd.quantum) begin
        if (qleft_r > QTW'(1)) qleft_r <= qleft_r - QTW'(1);
        else begin
          qleft_r <= '0;
          // pop from current, push to demoted (same level: count unchanged)
          rhead_r[cur_r] <= nxt(rhead_r[cur_r]);
          if (rcnt_r[dem] != CW'(QUEUE_DEPTH) || dem == cur_r) begin
            rtail_r[dem] <= nxt(rtail_r[dem]);
            if (dem != cur_r) begin
              rcnt_r[cur_r] <= rcnt_r[cur_r] - CW'(1);
              rcnt_r[dem] <= rcnt_r[dem] + CW'(1);
            end
          end else begin
            rcnt_r[cur_r] <= rcnt_r[cur_r] - CW'(1);
            status_r <= ST_FULL;
          end
        end
      end
      if (cmd.io_req || cmd.term) begin
        rhead_r[cur_r] <= nxt(rhead_r[cur_r]);
        rcnt_r[cur_r] <= rcnt_r[cur_r] - CW'(1);
        if (cmd.io_req) begin
          if (iocnt_r != CW'(QUEUE_DEPTH)) begin
            iotail_r <= nxt(iotail_r);
            iocnt_r <= iocnt_r + CW'(1);
          end else status_r <= ST_FULL;
        end
      end
      if (cmd.no_run) status_r <= ST_NO_RUN;
      if (cmd.dispatch) begin
        running_r <= any_rdy;
        if (any_rdy) begin
          cur_r <= pick;
          qleft_r <= QTW'(1) << pick;
        end
      end
      if (cmd.finish) begin
        res_run_valid <= running_r;
        res_run_pid <= running_r ? front_r : '0;
        res_run_level <= running_r ? 2'(cur_r) : 2'd0;
        res_switched <= (running_r != prev_valid_r)
                     || ((running_r ? front_r : '0) != prev_pid_r)
                     || ((running_r ? cur_r : '0) != prev_lvl_r);
        res_all_idle <= io_idle;
        res_status <= status_r;
      end
    end
  end

  // quantum never exceeds the top dispatch value
  a_qleft: assert property (@(posedge clk) disable iff (!rst_n)
    qleft_r <= (QTW'(1) << (LEVELS - 1)))
    else $error("quantum out of range");
  // io count bounded
  a_iocnt: assert property (@(posedge clk) disable iff (!rst_n)
    iocnt_r <= CW'(QUEUE_DEPTH))
    else $error("io count overflow");
  // a dispatch runs only when something is ready
  a_disp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dispatch && !any_rdy |=> !running_r)
    else $error("running with empty queues");

endmodule

/* sv/mlfs_ctrl.sv */
// ----------------------------------------------------------------------------
// mlfs_ctrl
// Sequencer: one event word at a time through drain, update, dispatch.
// ----------------------------------------------------------------------------
module mlfs_ctrl import mlfs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       out_busy,
  input  logic       out_fire,
  input  mlfs_stat_t stat,
  output logic       in_ready,
  output logic       out_valid,
  output mlfs_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RDF0  = 10'b0000000010,
    S_EXEC  = 10'b0000000100,
    S_IORD  = 10'b0000001000,
    S_IOCHK = 10'b0000010000,
    S_QUANT = 10'b0000100000,
    S_DISP  = 10'b0001000000,
    S_RDF1  = 10'b0010000000,
    S_DONE  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic ov_r, ov_nxt;

  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt = ov_r;
    cmd = '0;
    if (out_fire) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_fire) begin
        cmd.latch = 1'b1;
        state_nxt = S_RDF0;
      end
      S_RDF0: begin
        cmd.rd_front = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RDF1;
        case (stat.op)
          OP_TICK: begin
            cmd.tick = 1'b1;
            state_nxt = S_IORD;
          end
          OP_ARRIV: begin
            cmd.arrive = 1'b1;
            if (!stat.running) state_nxt = S_DISP;
          end
          default: begin
            if (!stat.running) cmd.no_run = 1'b1;
            else begin
              cmd.io_req = (stat.op == OP_IO);
              cmd.term = (stat.op == OP_TERM);
              state_nxt = S_DISP;
            end
          end
        endcase
      end
      S_IORD: begin
        if (stat.io_left) begin
          cmd.io_read = 1'b1;
          state_nxt = S_IOCHK;
        end else state_nxt = stat.running ? S_QUANT : S_DISP;
      end
      S_IOCHK: begin
        if (stat.io_due) begin
          cmd.io_pop = 1'b1;
          state_nxt = S_IORD;
        end else state_nxt = stat.running ? S_QUANT : S_DISP;
      end
      S_QUANT: begin
        cmd.quantum = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // quantum expiry needs a dispatch; otherwise refresh front
        state_nxt = stat.q_done ? S_DISP : S_RDF1;
      end
      S_DISP: begin
        cmd.dispatch = 1'b1;
        state_nxt = S_RDF1;
      end
      S_RDF1: begin
        cmd.rd_front = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: if (!out_busy || out_fire) begin
        cmd.finish = 1'b1;
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_RDF0)
    else $error("accept without start");
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("result lost");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state not one-hot");

endmodule

/* sv/multilevel_feedback_scheduler_core.sv */
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_core
// Three-level feedback scheduler: arrivals, ticks, io requests, exits.
//
// channel | dir | payload
// in_     | in  | tdata {pid, op}
// out_    | out | tdata {status, all_idle, switched, run_level, run_pid, run_valid}
// cfg_    | in  | io wait ticks, 8 bits
//
// an event word passes from accept to result word through the sequencer
// states; on a tick the sequencer steps the io queue memory one entry at
// a time, releasing each due entry.
// sync active-low reset; no clearing pass, stores are read only once written.
// a waiting result stalls the next accept until taken.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_core import mlfs_pkg::*; #(
  parameter int LEVELS      = LEVELS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int PID_BITS    = PID_BITS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [((PID_BITS+9)/8)*8-1:0]  in_tdata,   // op[1:0], pid
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [((PID_BITS+14)/8)*8-1:0] out_tdata   // run_valid, run_pid,
                                                     // run_level, switched,
                                                     // all_idle, status
);

  localparam int OUT_W = ((PID_BITS + 14) / 8) * 8;

  mlfs_cmd_t cmd;
  mlfs_stat_t stat;
  logic rv, sw, ai;
  logic [PID_BITS-1:0] rp;
  logic [1:0] rl, st;

  mlfs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_tvalid && in_tready),
    .out_busy(out_tvalid), .out_fire(out_tvalid && out_tready),
    .stat(stat), .in_ready(in_tready), .out_valid(out_tvalid), .cmd(cmd)
  );

  mlfs_dpath #(.LEVELS(LEVELS), .QUEUE_DEPTH(QUEUE_DEPTH),
               .PID_BITS(PID_BITS), .TIME_BITS(TIME_BITS)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .ev_op(in_tdata[1:0]), .ev_pid(in_tdata[PID_BITS+1:2]),
    .cmd(cmd), .stat(stat),
    .res_run_valid(rv), .res_run_pid(rp), .res_run_level(rl),
    .res_switched(sw), .res_all_idle(ai), .res_status(st)
  );

  // result fields, zero padded to whole bytes
  assign out_tdata = OUT_W'({st, ai, sw, rl, rp, rv});

endmodule
